// ----- hw/rtl/imrh_pkg.sv -----
// ----------------------------------------------------------------------------
// imrh_pkg: shared types and constants of the image-map region hit test
// Widths of coordinates, differences and products, command codes, register
// offsets, sequencer states and the request format of the shared multiplier.
// ----------------------------------------------------------------------------
package imrh_pkg;

    // geometry and identifier widths
    localparam int COORD_BITS   = 20;
    localparam int REGION_COUNT = 1024;
    localparam int REGION_BITS  = $clog2(REGION_COUNT);
    localparam int RADIUS_BITS  = COORD_BITS - 1;
    localparam int DIFF_BITS    = COORD_BITS + 1;
    localparam int PROD_BITS    = 2 * DIFF_BITS;
    localparam int ACC_BITS     = PROD_BITS + 1;

    // register port
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;
    localparam int REG_SEL_BIT   = 2;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic        [RADIUS_BITS-1:0] radius_t;
    typedef logic        [REGION_BITS-1:0] region_t;
    typedef logic signed [DIFF_BITS-1:0]  diff_t;
    typedef logic signed [PROD_BITS-1:0]  prod_t;
    typedef logic signed [ACC_BITS-1:0]   acc_t;
    typedef logic        [2:0]            cmd_t;
    typedef logic        [APB_ADDR_BITS-1:0] paddr_t;
    typedef logic        [APB_DATA_BITS-1:0] pdata_t;

    // command codes
    localparam cmd_t CMD_DEFAULT = 3'd0;
    localparam cmd_t CMD_RECT    = 3'd1;
    localparam cmd_t CMD_CIRCLE  = 3'd2;
    localparam cmd_t CMD_POLY    = 3'd3;
    localparam cmd_t CMD_END     = 3'd4;

    // register select (address bit REG_SEL_BIT)
    localparam logic REG_QUERY_X = 1'b0;
    localparam logic REG_QUERY_Y = 1'b1;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_RECT,
        S_CIRC_A,
        S_CIRC_B,
        S_CIRC_C,
        S_CIRC_CMP,
        S_EDGE_CHK,
        S_EDGE_MUL_A,
        S_EDGE_MUL_B,
        S_EDGE_CMP,
        S_POLY_END,
        S_EMIT
    } state_t;

    // operand pair for the shared multiplier
    typedef struct packed {
        diff_t op_a;
        diff_t op_b;
    } mul_req_t;

endpackage

// ----- hw/rtl/imrh_mul.sv -----
// ----------------------------------------------------------------------------
// imrh_mul: shared signed multiplier
// Multiplies the operand pair of the sequencer; product is registered and
// available in the cycle after the operands are presented.
// ----------------------------------------------------------------------------
module imrh_mul (
    input  logic               clk,
    input  imrh_pkg::mul_req_t req,
    output imrh_pkg::prod_t    prod
);
    import imrh_pkg::*;

    prod_t a_ext;
    prod_t b_ext;
    prod_t prod_reg;

    // sign-extend operands to product width
    assign a_ext = {{(PROD_BITS-DIFF_BITS){req.op_a[DIFF_BITS-1]}}, req.op_a};
    assign b_ext = {{(PROD_BITS-DIFF_BITS){req.op_b[DIFF_BITS-1]}}, req.op_b};

    // product register
    always_ff @(posedge clk)
    begin
        prod_reg <= a_ext * b_ext;
    end

    assign prod = prod_reg;

endmodule

// ----- hw/rtl/image_map_region_hit_test.sv -----
// ----------------------------------------------------------------------------
// image_map_region_hit_test: query point against a stream of map shapes
// Rectangles, circles, polygons (even-odd crossing test) and defaults are
// checked against the configured query point; the last shape hit wins.
// ----------------------------------------------------------------------------
// Usage:
//   Write query_x (offset 0) and query_y (offset 4) over the register port
//   while the block is idle. Shapes then arrive as beats on the input channel
//   (cmd, coord_x, coord_y, radius, region_id, shape_last). Every shape end,
//   default and end-of-map beat yields one result beat (shape_hit,
//   match_valid, match_region, map_done); other beats yield none.
// Sequence:
//   One beat is worked at a time by a small sequencer around one shared
//   21x21 multiplier. Each beat is dispatched first; a default or end of map
//   then goes to the result register, a rectangle through its compare, a
//   circle through three squares and a compare, a polygon's last vertex
//   through its edge checks: each edge is classified, and when it straddles
//   the point's row with the point between its x ends, two products and a
//   compare follow. Beats with no result free the input after dispatch or
//   their edge check; in_ready returns at the edge that loads the result.
// Stall and reset:
//   A finished result sits in the output register; the next beat is taken
//   meanwhile, and the sequencer waits before loading a new result until the
//   receiver has taken the previous one. Reset clears the query point, the
//   current match and any open shape.
// ----------------------------------------------------------------------------
module image_map_region_hit_test (
    input  logic              clk,
    input  logic              rst_n,
    // register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  imrh_pkg::paddr_t  paddr,
    input  imrh_pkg::pdata_t  pwdata,
    output imrh_pkg::pdata_t  prdata,
    output logic              pready,
    // shape channel
    input  logic              in_valid,
    output logic              in_ready,
    input  imrh_pkg::cmd_t    cmd,
    input  imrh_pkg::coord_t  coord_x,
    input  imrh_pkg::coord_t  coord_y,
    input  imrh_pkg::radius_t radius,
    input  imrh_pkg::region_t region_id,
    input  logic              shape_last,
    // result channel
    output logic              out_valid,
    input  logic              out_ready,
    output logic              shape_hit,
    output logic              match_valid,
    output imrh_pkg::region_t match_region,
    output logic              map_done
);
    import imrh_pkg::*;

    function automatic diff_t widen(coord_t v);
        return {v[COORD_BITS-1], v};
    endfunction

    // control state
    state_t  state_reg, state_next;
    logic    out_valid_reg, out_valid_next;
    logic    have_match_reg, have_match_next;
    region_t best_region_reg, best_region_next;
    coord_t  first_x_reg, first_x_next;
    coord_t  first_y_reg, first_y_next;
    coord_t  prev_x_reg, prev_x_next;
    coord_t  prev_y_reg, prev_y_next;
    logic    in_shape_reg, in_shape_next;
    logic    parity_reg, parity_next;
    logic    forced_reg, forced_next;
    logic    edge_sel_reg, edge_sel_next;
    coord_t  query_x_reg;
    coord_t  query_y_reg;

    // beat and working registers
    cmd_t    cmd_reg;
    coord_t  cur_x_reg;
    coord_t  cur_y_reg;
    radius_t radius_reg;
    region_t region_reg;
    logic    last_reg;
    acc_t    acc_reg, acc_next;
    logic    res_hit_reg, res_hit_next;
    logic    shape_hit_reg;
    logic    match_valid_reg;
    region_t match_region_reg;
    logic    map_done_reg;

    logic     cfg_wr;
    logic     in_take;
    logic     out_load;
    logic     edge_done;
    logic     hit_strobe;
    logic     hit_now;
    mul_req_t mul_req;
    prod_t    prod;
    acc_t     prod_ext;
    coord_t   x1, y1, x2, y2;
    logic     straddle;
    logic     right_of_both;
    logic     left_of_both;
    logic     on_hline;
    logic     cross_hit;
    logic     rect_hit;

    // register port
    assign cfg_wr = psel & penable & pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[REG_SEL_BIT] == REG_QUERY_Y)
                  ? {{(APB_DATA_BITS-COORD_BITS){query_y_reg[COORD_BITS-1]}}, query_y_reg}
                  : {{(APB_DATA_BITS-COORD_BITS){query_x_reg[COORD_BITS-1]}}, query_x_reg};

    // handshakes
    assign in_ready = (state_reg == S_IDLE);
    assign in_take  = in_valid & in_ready;

    // shared multiplier
    imrh_mul u_mul (
        .clk  (clk),
        .req  (mul_req),
        .prod (prod)
    );

    assign prod_ext = {prod[PROD_BITS-1], prod};

    // edge endpoints: polygon edge or closing edge
    assign x1 = edge_sel_reg ? cur_x_reg   : prev_x_reg;
    assign y1 = edge_sel_reg ? cur_y_reg   : prev_y_reg;
    assign x2 = edge_sel_reg ? first_x_reg : cur_x_reg;
    assign y2 = edge_sel_reg ? first_y_reg : cur_y_reg;

    // edge classification against the query point
    assign straddle = ((y1 <= query_y_reg) && (y2 > query_y_reg))
                   || ((y1 > query_y_reg) && (y2 <= query_y_reg));
    assign right_of_both = (query_x_reg >= x1) && (query_x_reg >= x2);
    assign left_of_both  = (query_x_reg < x1) && (query_x_reg < x2);
    assign on_hline = (y1 == y2) && (query_y_reg == y1)
                   && (((query_x_reg >= x1) && (query_x_reg <= x2))
                    || ((query_x_reg <= x1) && (query_x_reg >= x2)));

    // intercept test by cross products, acc holds (qx-x1)*(y2-y1)
    assign cross_hit = (y2 > y1) ? (acc_reg >= prod_ext) : (acc_reg <= prod_ext);

    // inclusive rectangle spanned by first and final corner
    assign rect_hit = (((query_x_reg >= first_x_reg) && (query_x_reg <= cur_x_reg))
                    || ((query_x_reg >= cur_x_reg) && (query_x_reg <= first_x_reg)))
                   && (((query_y_reg >= first_y_reg) && (query_y_reg <= cur_y_reg))
                    || ((query_y_reg >= cur_y_reg) && (query_y_reg <= first_y_reg)));

    // multiplier operand selection
    always_comb
    begin
        mul_req.op_a = '0;
        mul_req.op_b = '0;
        case (state_reg)
            S_EDGE_MUL_A:
            begin
                mul_req.op_a = widen(query_x_reg) - widen(x1);
                mul_req.op_b = widen(y2) - widen(y1);
            end
            S_EDGE_MUL_B:
            begin
                mul_req.op_a = widen(x2) - widen(x1);
                mul_req.op_b = widen(query_y_reg) - widen(y1);
            end
            S_CIRC_A:
            begin
                mul_req.op_a = widen(query_x_reg) - widen(cur_x_reg);
                mul_req.op_b = widen(query_x_reg) - widen(cur_x_reg);
            end
            S_CIRC_B:
            begin
                mul_req.op_a = widen(query_y_reg) - widen(cur_y_reg);
                mul_req.op_b = widen(query_y_reg) - widen(cur_y_reg);
            end
            S_CIRC_C:
            begin
                mul_req.op_a = {{(DIFF_BITS-RADIUS_BITS){1'b0}}, radius_reg};
                mul_req.op_b = {{(DIFF_BITS-RADIUS_BITS){1'b0}}, radius_reg};
            end
            default:
            begin
                mul_req.op_a = '0;
                mul_req.op_b = '0;
            end
        endcase
    end

    // sequencer: next state and working values
    always_comb
    begin
        state_next       = state_reg;
        have_match_next  = have_match_reg;
        best_region_next = best_region_reg;
        first_x_next     = first_x_reg;
        first_y_next     = first_y_reg;
        prev_x_next      = prev_x_reg;
        prev_y_next      = prev_y_reg;
        in_shape_next    = in_shape_reg;
        parity_next      = parity_reg;
        forced_next      = forced_reg;
        edge_sel_next    = edge_sel_reg;
        acc_next         = acc_reg;
        res_hit_next     = res_hit_reg;
        out_load         = 1'b0;
        edge_done        = 1'b0;
        hit_strobe       = 1'b0;
        hit_now          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (cmd_reg)
                    CMD_DEFAULT:
                    begin
                        in_shape_next = 1'b0;
                        res_hit_next  = !have_match_reg;
                        if (!have_match_reg)
                        begin
                            have_match_next  = 1'b1;
                            best_region_next = region_reg;
                        end
                        state_next = S_EMIT;
                    end
                    CMD_RECT:
                    begin
                        if (!in_shape_reg)
                        begin
                            first_x_next = cur_x_reg;
                            first_y_next = cur_y_reg;
                            parity_next  = 1'b0;
                            forced_next  = 1'b0;
                        end
                        prev_x_next   = cur_x_reg;
                        prev_y_next   = cur_y_reg;
                        in_shape_next = !last_reg;
                        state_next    = last_reg ? S_RECT : S_IDLE;
                    end
                    CMD_CIRCLE:
                    begin
                        in_shape_next = 1'b0;
                        state_next    = S_CIRC_A;
                    end
                    CMD_POLY:
                    begin
                        in_shape_next = !last_reg;
                        if (!in_shape_reg)
                        begin
                            // open the polygon, only the closing edge if single
                            first_x_next  = cur_x_reg;
                            first_y_next  = cur_y_reg;
                            parity_next   = 1'b0;
                            forced_next   = 1'b0;
                            prev_x_next   = cur_x_reg;
                            prev_y_next   = cur_y_reg;
                            edge_sel_next = 1'b1;
                            state_next    = last_reg ? S_EDGE_CHK : S_IDLE;
                        end
                        else
                        begin
                            edge_sel_next = 1'b0;
                            state_next    = S_EDGE_CHK;
                        end
                    end
                    CMD_END:
                    begin
                        in_shape_next = 1'b0;
                        res_hit_next  = 1'b0;
                        state_next    = S_EMIT;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_RECT:
            begin
                hit_strobe = 1'b1;
                hit_now    = rect_hit;
                state_next = S_EMIT;
            end
            S_CIRC_A:
            begin
                state_next = S_CIRC_B;
            end
            S_CIRC_B:
            begin
                acc_next   = prod_ext;
                state_next = S_CIRC_C;
            end
            S_CIRC_C:
            begin
                acc_next   = acc_reg + prod_ext;
                state_next = S_CIRC_CMP;
            end
            S_CIRC_CMP:
            begin
                hit_strobe = 1'b1;
                hit_now    = (acc_reg <= prod_ext);
                state_next = S_EMIT;
            end
            S_EDGE_CHK:
            begin
                if (forced_reg)
                begin
                    edge_done = 1'b1;
                end
                else if (straddle)
                begin
                    if (right_of_both)
                    begin
                        parity_next = !parity_reg;
                        edge_done   = 1'b1;
                    end
                    else if (left_of_both)
                    begin
                        edge_done = 1'b1;
                    end
                    else
                    begin
                        state_next = S_EDGE_MUL_A;
                    end
                end
                else
                begin
                    if (on_hline)
                    begin
                        forced_next = 1'b1;
                    end
                    edge_done = 1'b1;
                end
            end
            S_EDGE_MUL_A:
            begin
                state_next = S_EDGE_MUL_B;
            end
            S_EDGE_MUL_B:
            begin
                acc_next   = prod_ext;
                state_next = S_EDGE_CMP;
            end
            S_EDGE_CMP:
            begin
                if (cross_hit)
                begin
                    parity_next = !parity_reg;
                end
                edge_done = 1'b1;
            end
            S_POLY_END:
            begin
                hit_strobe = 1'b1;
                hit_now    = forced_reg || parity_reg;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load = 1'b1;
                    if (cmd_reg == CMD_END)
                    begin
                        have_match_next  = 1'b0;
                        best_region_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // after an edge: move on to the closing edge or finish the vertex
        if (edge_done)
        begin
            if (!edge_sel_reg)
            begin
                prev_x_next = cur_x_reg;
                prev_y_next = cur_y_reg;
            end
            if (!edge_sel_reg && last_reg)
            begin
                edge_sel_next = 1'b1;
                state_next    = S_EDGE_CHK;
            end
            else if (last_reg)
            begin
                state_next = S_POLY_END;
            end
            else
            begin
                state_next = S_IDLE;
            end
        end

        // shape result and winning region
        if (hit_strobe)
        begin
            res_hit_next = hit_now;
            if (hit_now)
            begin
                have_match_next  = 1'b1;
                best_region_next = region_reg;
            end
        end
    end

    assign out_valid_next = out_load | (out_valid_reg & ~out_ready);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            out_valid_reg   <= 1'b0;
            have_match_reg  <= 1'b0;
            best_region_reg <= '0;
            first_x_reg     <= '0;
            first_y_reg     <= '0;
            prev_x_reg      <= '0;
            prev_y_reg      <= '0;
            in_shape_reg    <= 1'b0;
            parity_reg      <= 1'b0;
            forced_reg      <= 1'b0;
            edge_sel_reg    <= 1'b0;
            query_x_reg     <= '0;
            query_y_reg     <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            out_valid_reg   <= out_valid_next;
            have_match_reg  <= have_match_next;
            best_region_reg <= best_region_next;
            first_x_reg     <= first_x_next;
            first_y_reg     <= first_y_next;
            prev_x_reg      <= prev_x_next;
            prev_y_reg      <= prev_y_next;
            in_shape_reg    <= in_shape_next;
            parity_reg      <= parity_next;
            forced_reg      <= forced_next;
            edge_sel_reg    <= edge_sel_next;
            if (cfg_wr && (paddr[REG_SEL_BIT] == REG_QUERY_X))
            begin
                query_x_reg <= pwdata[COORD_BITS-1:0];
            end
            if (cfg_wr && (paddr[REG_SEL_BIT] == REG_QUERY_Y))
            begin
                query_y_reg <= pwdata[COORD_BITS-1:0];
            end
        end
    end

    // beat capture, working values and result payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg    <= cmd;
            cur_x_reg  <= coord_x;
            cur_y_reg  <= coord_y;
            radius_reg <= radius;
            region_reg <= region_id;
            last_reg   <= shape_last;
        end
        acc_reg     <= acc_next;
        res_hit_reg <= res_hit_next;
        if (out_load)
        begin
            shape_hit_reg    <= res_hit_reg;
            match_valid_reg  <= have_match_reg;
            match_region_reg <= best_region_reg;
            map_done_reg     <= (cmd_reg == CMD_END);
        end
    end

    assign out_valid    = out_valid_reg;
    assign shape_hit    = shape_hit_reg;
    assign match_valid  = match_valid_reg;
    assign match_region = match_region_reg;
    assign map_done     = map_done_reg;

`ifndef SYNTH
    // one beat in flight: no second accept right after one
    a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("beat accepted while previous beat still in work");

    // no match means region zero on every result
    a_region_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !match_valid |-> match_region == '0)
        else $error("region reported without a match");

    // end of map clears the running match
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && (cmd_reg == CMD_END) |=> !have_match_reg && best_region_reg == '0)
        else $error("match survived end of map");

    // a forced polygon counts no further crossings
    a_forced_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EDGE_CHK) && forced_reg |=> $stable(parity_reg))
        else $error("crossing counted after forced hit");
`endif

endmodule

// ----- sim/image_map_region_hit_test_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// image_map_region_hit_test_tb: self-checking bench for the map hit tester
// Walks a short table of directed shapes, then streams random rectangles,
// circles, polygons, defaults and end-of-map beats under several query points.
// A local shape-hit predictor, or the table for typed rows, builds the
// expected beats, checked field by field. Both channels idle at random.
// ----------------------------------------------------------------------------
module image_map_region_hit_test_tb;

    import imrh_pkg::*;

    // unused command codes, ignored by the block
    localparam cmd_t CMD_RSVD_5 = 3'd5;
    localparam cmd_t CMD_RSVD_7 = 3'd7;

    localparam coord_t  CRD_MIN = 20'sh80000;
    localparam coord_t  CRD_MAX = 20'sh7FFFF;
    localparam coord_t  CRD_0   = 20'sd0;
    localparam radius_t RAD_MAX = '1;

    localparam int IDLE_WAIT    = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 125;
    localparam int DIR_ROWS     = 27;

    typedef struct packed {
        logic    shape_hit;
        logic    match_valid;
        region_t match_region;
        logic    map_done;
    } hit_res_t;

    typedef struct packed {
        cmd_t     cmd;
        coord_t   x;
        coord_t   y;
        radius_t  r;
        region_t  id;
        logic     last;
        logic     typed;
        hit_res_t want;
    } stim_row_t;

    // dut signals
    logic    clk;
    logic    rst_n;
    logic    psel;
    logic    penable;
    logic    pwrite;
    paddr_t  paddr;
    pdata_t  pwdata;
    pdata_t  prdata;
    logic    pready;
    logic    in_valid;
    logic    in_ready;
    cmd_t    cmd;
    coord_t  coord_x;
    coord_t  coord_y;
    radius_t radius;
    region_t region_id;
    logic    shape_last;
    logic    out_valid;
    logic    out_ready;
    logic    shape_hit;
    logic    match_valid;
    region_t match_region;
    logic    map_done;

    // bench control
    hit_res_t  pending_results[$];
    hit_res_t  oldest;
    int        errors;
    bit        calm;
    bit        hold_req;
    int        hold_left;
    stim_row_t dir_tab [0:DIR_ROWS-1];

    // predictor copy of the query point and the block state
    coord_t  q_x;
    coord_t  q_y;
    logic    hold_match;
    region_t win_region;
    longint  open_x, open_y, last_x, last_y;
    logic    shape_open;
    logic    odd_cross;
    logic    on_hline;

    image_map_region_hit_test dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .radius       (radius),
        .region_id    (region_id),
        .shape_last   (shape_last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .shape_hit    (shape_hit),
        .match_valid  (match_valid),
        .match_region (match_region),
        .map_done     (map_done)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("image_map_region_hit_test_tb NOT OK");
        $finish;
    end

    // start a new open shape at its first corner or vertex
    function automatic void open_shape(input longint x, input longint y);
        open_x     = x;
        open_y     = y;
        odd_cross  = 1'b0;
        on_hline   = 1'b0;
        shape_open = 1'b1;
    endfunction

    // one polygon edge: crossing toggle or horizontal-edge hit
    function automatic void cross_edge(input longint x1, input longint y1,
                                       input longint x2, input longint y2);
        longint qx, qy, d, lhs, rhs;
        qx = longint'(q_x);
        qy = longint'(q_y);
        if (on_hline)
            return;
        if ((y1 <= qy && y2 > qy) || (y1 > qy && y2 <= qy))
        begin
            if (qx >= x1 && qx >= x2)
                odd_cross = ~odd_cross;
            else if (!(qx < x1 && qx < x2))
            begin
                // exact intercept compare by cross-multiplying with the y span
                d   = y2 - y1;
                lhs = (qx - x1) * d;
                rhs = (x2 - x1) * (qy - y1);
                if ((d > 0 && lhs >= rhs) || (d < 0 && lhs <= rhs))
                    odd_cross = ~odd_cross;
            end
        end
        else if (y1 == y2 && qy == y1)
        begin
            if ((qx >= x1 && qx <= x2) || (qx <= x1 && qx >= x2))
                on_hline = 1'b1;
        end
    endfunction

    // expected result of one accepted beat
    function automatic void predict_beat(input cmd_t c, input coord_t x, input coord_t y,
                                         input radius_t r, input region_t id,
                                         input logic last,
                                         output logic has, output hit_res_t res);
        longint qx, qy, vx, vy, lx, hx, ly, hy, dx, dy;
        logic   hit;
        qx  = longint'(q_x);
        qy  = longint'(q_y);
        vx  = longint'(x);
        vy  = longint'(y);
        has = 1'b0;
        hit = 1'b0;
        res = '0;
        case (c)
            CMD_DEFAULT:
            begin
                shape_open = 1'b0;
                hit = !hold_match;
                has = 1'b1;
            end
            CMD_RECT:
            begin
                if (!shape_open)
                    open_shape(vx, vy);
                last_x = vx;
                last_y = vy;
                if (last)
                begin
                    // first corner and final corner span the rectangle
                    shape_open = 1'b0;
                    lx  = (open_x < vx) ? open_x : vx;
                    hx  = (open_x > vx) ? open_x : vx;
                    ly  = (open_y < vy) ? open_y : vy;
                    hy  = (open_y > vy) ? open_y : vy;
                    hit = (qx >= lx && qx <= hx && qy >= ly && qy <= hy);
                    has = 1'b1;
                end
            end
            CMD_CIRCLE:
            begin
                shape_open = 1'b0;
                dx  = qx - vx;
                dy  = qy - vy;
                hit = (dx * dx + dy * dy <= longint'(r) * longint'(r));
                has = 1'b1;
            end
            CMD_POLY:
            begin
                if (!shape_open)
                    open_shape(vx, vy);
                else
                    cross_edge(last_x, last_y, vx, vy);
                last_x = vx;
                last_y = vy;
                if (last)
                begin
                    // closing edge back to the first vertex
                    cross_edge(vx, vy, open_x, open_y);
                    shape_open = 1'b0;
                    hit = on_hline || odd_cross;
                    has = 1'b1;
                end
            end
            CMD_END:
            begin
                shape_open = 1'b0;
                res = '{1'b0, hold_match, win_region, 1'b1};
                hold_match = 1'b0;
                win_region = '0;
                has = 1'b1;
                return;
            end
            default:
                has = 1'b0;
        endcase
        if (has)
        begin
            if (hit)
            begin
                hold_match = 1'b1;
                win_region = id;
            end
            res = '{hit, hold_match, win_region, 1'b0};
        end
    endfunction

    // offer one beat, wait for it to be taken, then record its expectation
    task automatic send_item(input cmd_t c, input coord_t x, input coord_t y,
                             input radius_t r, input region_t id, input logic last,
                             input logic typed, input hit_res_t want);
        logic     has;
        hit_res_t res;
        @(negedge clk);
        if (!calm && $urandom_range(0, 99) < 25)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        cmd        <= c;
        coord_x    <= x;
        coord_y    <= y;
        radius     <= r;
        region_id  <= id;
        shape_last <= last;
        in_valid   <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        predict_beat(c, x, y, r, id, last, has, res);
        if (has)
            pending_results.push_back(typed ? want : res);
    endtask

    // stop offering, wait for every expected beat and for the block to settle
    task automatic drain_and_settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (IDLE_WAIT) @(posedge clk);
    endtask

    // register write: setup cycle then access cycle
    task automatic write_reg(input logic sel, input coord_t v);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= paddr_t'(sel) << REG_SEL_BIT;
        pwdata  <= {{(APB_DATA_BITS-COORD_BITS){v[COORD_BITS-1]}}, v};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (sel == REG_QUERY_X)
            q_x = v;
        else
            q_y = v;
    endtask

    // point near the given coordinate, wrapping at the field width
    function automatic coord_t near_pt(input coord_t q, input int sp);
        int off;
        if ($urandom_range(0, 9) == 0)
            return q;
        off = int'($urandom_range(0, 2 * sp)) - sp;
        return coord_t'(int'(q) + off);
    endfunction

    // one random shape, mostly well formed, some noise and broken shapes
    task automatic send_shape(input int sp, inout int sent);
        int      kind, n, rmax;
        cmd_t    c;
        coord_t  x, y;
        radius_t r;
        region_t id;
        logic    drop_last;
        kind = $urandom_range(0, 99);
        id   = region_t'($urandom_range(0, REGION_COUNT - 1));
        rmax = 2 * sp;
        if (rmax > int'(RAD_MAX))
            rmax = int'(RAD_MAX);
        if (kind < 6)
        begin
            // noise: any code, any field
            c = cmd_t'($urandom_range(0, 7));
            send_item(c, coord_t'($urandom), coord_t'($urandom), radius_t'($urandom), id,
                      logic'($urandom_range(0, 1)), 1'b0, '0);
            if (c <= CMD_END)
                sent++;
        end
        else if (kind < 14)
        begin
            send_item(CMD_DEFAULT, near_pt(q_x, sp), near_pt(q_y, sp), radius_t'($urandom),
                      id, logic'($urandom_range(0, 1)), 1'b0, '0);
            sent++;
        end
        else if (kind < 18)
        begin
            send_item(CMD_END, coord_t'($urandom), coord_t'($urandom), radius_t'($urandom),
                      id, logic'($urandom_range(0, 1)), 1'b0, '0);
            sent++;
        end
        else if (kind < 42)
        begin
            n = $urandom_range(1, 3);
            drop_last = ($urandom_range(0, 15) == 0);
            for (int i = 0; i < n; i++)
            begin
                send_item(CMD_RECT, near_pt(q_x, sp), near_pt(q_y, sp), radius_t'($urandom),
                          id, (i == n - 1) && !drop_last, 1'b0, '0);
                sent++;
            end
        end
        else if (kind < 64)
        begin
            if ($urandom_range(0, 9) == 0)
                r = radius_t'($urandom);
            else
                r = radius_t'($urandom_range(0, rmax));
            send_item(CMD_CIRCLE, near_pt(q_x, sp), near_pt(q_y, sp), r, id,
                      logic'($urandom_range(0, 1)), 1'b0, '0);
            sent++;
        end
        else
        begin
            // polygon, some vertices on the query row for horizontal edges
            n = $urandom_range(1, 6);
            drop_last = ($urandom_range(0, 11) == 0);
            for (int i = 0; i < n; i++)
            begin
                x = near_pt(q_x, sp);
                y = ($urandom_range(0, 5) == 0) ? q_y : near_pt(q_y, sp);
                send_item(CMD_POLY, x, y, radius_t'($urandom), id,
                          (i == n - 1) && !drop_last, 1'b0, '0);
                sent++;
            end
        end
    endtask

    // result receiver with random stalls and one long hold-off
    initial
    begin
        out_ready = 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (calm)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 99) >= 25);
        end
    end

    // result beat check against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with no expectation waiting");
                errors++;
            end
            else
            begin
                oldest = pending_results.pop_front();
                if (shape_hit !== oldest.shape_hit)
                begin
                    $error("shape_hit mismatch: expected %0d, actual %0d",
                           oldest.shape_hit, shape_hit);
                    errors++;
                end
                if (match_valid !== oldest.match_valid)
                begin
                    $error("match_valid mismatch: expected %0d, actual %0d",
                           oldest.match_valid, match_valid);
                    errors++;
                end
                if (match_region !== oldest.match_region)
                begin
                    $error("match_region mismatch: expected %0d, actual %0d",
                           oldest.match_region, match_region);
                    errors++;
                end
                if (map_done !== oldest.map_done)
                begin
                    $error("map_done mismatch: expected %0d, actual %0d",
                           oldest.map_done, map_done);
                    errors++;
                end
            end
        end
    end

    // main sequence
    initial
    begin
        int     sent, sp;
        bit     held, paused;
        coord_t nx, ny;

        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        in_valid   = 1'b0;
        cmd        = CMD_DEFAULT;
        coord_x    = '0;
        coord_y    = '0;
        radius     = '0;
        region_id  = '0;
        shape_last = 1'b0;
        errors     = 0;
        calm       = 1'b0;
        hold_req   = 1'b0;

        q_x        = '0;
        q_y        = '0;
        hold_match = 1'b0;
        win_region = '0;
        open_x     = 0;
        open_y     = 0;
        last_x     = 0;
        last_y     = 0;
        shape_open = 1'b0;
        odd_cross  = 1'b0;
        on_hline   = 1'b0;

        // directed shapes against the reset query point (0, 0)
        dir_tab = '{
            // end of map straight after reset
            '{CMD_END, CRD_0, CRD_0, 19'd0, 10'd0, 1'b1, 1'b1, '{1'b0, 1'b0, 10'd0, 1'b1}},
            // default taken, then refused once matched
            '{CMD_DEFAULT, CRD_0, CRD_0, 19'd0, 10'd5, 1'b0, 1'b1,
              '{1'b1, 1'b1, 10'd5, 1'b0}},
            '{CMD_DEFAULT, CRD_0, CRD_0, 19'd0, 10'd7, 1'b0, 1'b1,
              '{1'b0, 1'b1, 10'd5, 1'b0}},
            // one-point rectangle on the query point
            '{CMD_RECT, CRD_0, CRD_0, 19'd0, 10'd10, 1'b1, 1'b1,
              '{1'b1, 1'b1, 10'd10, 1'b0}},
            // full-range rectangle, top region id
            '{CMD_RECT, CRD_MIN, CRD_MIN, 19'd0, 10'd0, 1'b0, 1'b0, '0},
            '{CMD_RECT, CRD_MAX, CRD_MAX, 19'd0, 10'd1023, 1'b1, 1'b1,
              '{1'b1, 1'b1, 10'd1023, 1'b0}},
            // circles at the coordinate extremes miss
            '{CMD_CIRCLE, CRD_MAX, CRD_MAX, 19'd0, 10'd3, 1'b0, 1'b1,
              '{1'b0, 1'b1, 10'd1023, 1'b0}},
            '{CMD_CIRCLE, CRD_MIN, CRD_MIN, RAD_MAX, 10'd0, 1'b1, 1'b1,
              '{1'b0, 1'b1, 10'd1023, 1'b0}},
            // zero radius on the point, then exactly on the rim
            '{CMD_CIRCLE, CRD_0, CRD_0, 19'd0, 10'd2, 1'b0, 1'b1,
              '{1'b1, 1'b1, 10'd2, 1'b0}},
            '{CMD_CIRCLE, 20'sd3, 20'sd4, 19'd5, 10'd4, 1'b0, 1'b1,
              '{1'b1, 1'b1, 10'd4, 1'b0}},
            // triangle around the point
            '{CMD_POLY, -20'sd16, -20'sd16, 19'd0, 10'd0, 1'b0, 1'b0, '0},
            '{CMD_POLY, 20'sd16, -20'sd16, 19'd0, 10'd0, 1'b0, 1'b0, '0},
            '{CMD_POLY, CRD_0, 20'sd16, 19'd0, 10'd20, 1'b1, 1'b0, '0},
            // horizontal edge through the point forces a hit
            '{CMD_POLY, -20'sd16, CRD_0, 19'd0, 10'd0, 1'b0, 1'b0, '0},
            '{CMD_POLY, 20'sd16, CRD_0, 19'd0, 10'd0, 1'b0, 1'b0, '0},
            '{CMD_POLY, 20'sd16, 20'sd16, 19'd0, 10'd21, 1'b1, 1'b0, '0},
            // single-vertex polygons, on and off the point
            '{CMD_POLY, CRD_0, CRD_0, 19'd0, 10'd22, 1'b1, 1'b1,
              '{1'b1, 1'b1, 10'd22, 1'b0}},
            '{CMD_POLY, 20'sd5, CRD_0, 19'd0, 10'd23, 1'b1, 1'b1,
              '{1'b0, 1'b1, 10'd22, 1'b0}},
            // shape opened as a rectangle, continued as a polygon
            '{CMD_RECT, -20'sd32, -20'sd32, 19'd0, 10'd0, 1'b0, 1'b0, '0},
            '{CMD_POLY, 20'sd32, -20'sd32, 19'd0, 10'd0, 1'b0, 1'b0, '0},
            '{CMD_POLY, CRD_0, 20'sd32, 19'd0, 10'd24, 1'b1, 1'b0, '0},
            // circle abandons the open rectangle
            '{CMD_RECT, 20'sd1, 20'sd1, 19'd0, 10'd0, 1'b0, 1'b0, '0},
            '{CMD_CIRCLE, 20'sd100, 20'sd100, 19'd1, 10'd9, 1'b1, 1'b0, '0},
            '{CMD_RECT, 20'sd1, 20'sd1, 19'd0, 10'd11, 1'b1, 1'b0, '0},
            // unused codes are ignored
            '{CMD_RSVD_5, CRD_0, CRD_0, 19'd0, 10'd1, 1'b1, 1'b0, '0},
            '{CMD_RSVD_7, CRD_MAX, CRD_MIN, RAD_MAX, 10'd1023, 1'b1, 1'b0, '0},
            '{CMD_END, CRD_0, CRD_0, 19'd0, 10'd0, 1'b0, 1'b0, '0}
        };

        // hold reset, then release it at a falling edge
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
            send_item(dir_tab[i].cmd, dir_tab[i].x, dir_tab[i].y, dir_tab[i].r,
                      dir_tab[i].id, dir_tab[i].last, dir_tab[i].typed, dir_tab[i].want);

        // random phases, each under its own query point
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain_and_settle();
            case (ph)
                0:       begin nx = CRD_MIN; ny = CRD_MIN; end
                1:       begin nx = CRD_MAX; ny = CRD_MAX; end
                2:       begin nx = CRD_MIN; ny = CRD_MAX; end
                7:       begin nx = CRD_0;   ny = CRD_0;   end
                default: begin nx = coord_t'($urandom); ny = coord_t'($urandom); end
            endcase
            write_reg(REG_QUERY_X, nx);
            write_reg(REG_QUERY_Y, ny);
            calm   = (ph == 3);
            sent   = 0;
            held   = 1'b0;
            paused = 1'b0;
            while (sent < PHASE_ITEMS)
            begin
                // long receiver hold-off while beats keep coming
                if (ph == 2 && sent >= 20 && !held)
                begin
                    hold_req = 1'b1;
                    held     = 1'b1;
                end
                // sender pause until all results are back
                if (ph == 5 && sent >= 60 && !paused)
                begin
                    drain_and_settle();
                    paused = 1'b1;
                end
                case ($urandom_range(0, 5))
                    0, 1:    sp = 2;
                    2, 3:    sp = 32;
                    4:       sp = 1024;
                    default: sp = 1 << (COORD_BITS - 1);
                endcase
                send_shape(sp, sent);
            end
            calm = 1'b0;
        end

        // wind down
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (IDLE_WAIT) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d expected result beats never arrived", pending_results.size());
            errors++;
        end
        if (errors == 0)
            $display("image_map_region_hit_test_tb OK");
        else
            $display("image_map_region_hit_test_tb NOT OK");
        $finish;
    end

endmodule
